FILE: design/frod_pkg.sv
// Shared types and constants of the length-prefixed frame ring.
// Used by frod_front, frod_back and frame_ring_drop_oldest.
// No dependencies.
package frod_pkg;

  localparam int FROD_RING_BYTES = 65536;
  localparam int FROD_QDEPTH     = 2;
  localparam logic [15:0] FROD_MAX_LEN_RST = 16'd4096;

  // Raw command codes on the input port
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Write status codes
  localparam logic [2:0] WS_NONE    = 3'd0;
  localparam logic [2:0] WS_ACCEPT  = 3'd1;
  localparam logic [2:0] WS_COMMIT  = 3'd2;
  localparam logic [2:0] WS_REJECT  = 3'd3;
  localparam logic [2:0] WS_NO_OPEN = 3'd4;
  localparam logic [2:0] WS_ABANDON = 3'd5;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_WR_START,
    OP_WR_APPEND,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data_byte;
    logic [15:0] frame_len;
    logic        len_ok;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        read_valid;
    logic        frame_end;
    logic        read_restart;
    logic [2:0]  write_status;
    logic [15:0] bytes_used;
    logic [31:0] frames_total;
    logic [31:0] frames_dropped;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ROOM,
    S_HISSUE,
    S_HTAKE,
    S_HEVAL,
    S_WHDR,
    S_WBYTE,
    S_RISSUE,
    S_RTAKE,
    S_DONE
  } bst_t;

endpackage

FILE: design/frame_ring_drop_oldest.sv
// Top level of the length-prefixed frame ring that drops oldest frames.
// Depends on frod_pkg, frod_front, frod_fifo and frod_back.
//
//  channel   handshake            payload
//  -------   ------------------   ----------------------------------------------
//  input     push / full          in_command, in_data_byte, in_first_of_frame,
//                                 in_frame_len
//  result    empty / pop          out_read_data .. out_frames_dropped (one per item)
//  config    cfg_valid/cfg_ready  cfg_data (max_frame_len)
//
// An append writes one byte and a read inside an open frame reads one; a read that
// opens a frame first fetches its header, a frame start writes the four-byte header and
// its first byte; each dropped frame adds a fetch of its four header bytes, one by one.
// Synchronous active-low reset; the ring contents are not cleared.
// Two-entry queues decouple the input from the sequencer and the sequencer
// from the result side, so either side may stall.
module frame_ring_drop_oldest #(
  parameter int RING_BYTES = frod_pkg::FROD_RING_BYTES,
  parameter int QDEPTH     = frod_pkg::FROD_QDEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_of_frame,
  input  logic [15:0] in_frame_len,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_read_data,
  output logic        out_read_valid,
  output logic        out_frame_end,
  output logic        out_read_restart,
  output logic [2:0]  out_write_status,
  output logic [15:0] out_bytes_used,
  output logic [31:0] out_frames_total,
  output logic [31:0] out_frames_dropped
);
  import frod_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

  cmd_t front_cmd, back_cmd;
  res_t back_res, out_res;
  logic cmd_empty, cmd_pop, res_full, res_push;

  // Classify the incoming item and hold the length limit
  frod_front #(.RING_BYTES(RING_BYTES)) u_front (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_data,
    .in_command, .in_data_byte, .in_first_of_frame, .in_frame_len,
    .cmd_o(front_cmd)
  );

  // Queue classified commands toward the sequencer
  frod_fifo #(.WIDTH(CMD_W), .DEPTH(QDEPTH)) u_cmd_q (
    .clk, .rst_n,
    .push(push), .push_data(front_cmd), .full(full),
    .pop(cmd_pop), .pop_data(back_cmd), .empty(cmd_empty)
  );

  // Execute commands against the ring
  frod_back #(.RING_BYTES(RING_BYTES)) u_back (
    .clk, .rst_n,
    .cmd_i(back_cmd), .cmd_empty, .cmd_pop,
    .res_o(back_res), .res_full, .res_push
  );

  // Hold finished transactions until the consumer pops them
  frod_fifo #(.WIDTH(RES_W), .DEPTH(QDEPTH)) u_res_q (
    .clk, .rst_n,
    .push(res_push), .push_data(back_res), .full(res_full),
    .pop(pop), .pop_data(out_res), .empty(empty)
  );

  assign out_read_data      = out_res.read_data;
  assign out_read_valid     = out_res.read_valid;
  assign out_frame_end      = out_res.frame_end;
  assign out_read_restart   = out_res.read_restart;
  assign out_write_status   = out_res.write_status;
  assign out_bytes_used     = out_res.bytes_used;
  assign out_frames_total   = out_res.frames_total;
  assign out_frames_dropped = out_res.frames_dropped;

endmodule

FILE: design/frod_fifo.sv
// Small first-in first-out queue of packed words.
// Depends on nothing but its parameters.
module frod_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [IW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == IW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == IW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: design/frod_front.sv
// Front end: holds the length limit register and classifies input items.
// Depends on frod_pkg.
module frod_front #(
  parameter int RING_BYTES = frod_pkg::FROD_RING_BYTES
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [15:0]    cfg_data,
  input  logic [1:0]     in_command,
  input  logic [7:0]     in_data_byte,
  input  logic           in_first_of_frame,
  input  logic [15:0]    in_frame_len,
  output frod_pkg::cmd_t cmd_o
);
  import frod_pkg::*;

  logic [15:0] max_len_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= FROD_MAX_LEN_RST;
    end else if (cfg_valid) begin
      max_len_r <= cfg_data;
    end
  end

  always_comb begin
    cmd_o.data_byte = in_data_byte;
    cmd_o.frame_len = in_frame_len;
    cmd_o.len_ok    = (in_frame_len != '0) && (in_frame_len <= max_len_r) &&
                      ((32'(in_frame_len) + 32'd4) <= 32'(RING_BYTES - 1));
    case (in_command)
      CMD_WRITE: cmd_o.op = in_first_of_frame ? OP_WR_START : OP_WR_APPEND;
      CMD_READ:  cmd_o.op = OP_READ;
      CMD_CLEAR: cmd_o.op = OP_CLEAR;
      default:   cmd_o.op = OP_NOP;
    endcase
  end

endmodule

FILE: design/frod_back.sv
// Back end: sequencer over the byte ring memory that executes commands.
// Depends on frod_pkg.
module frod_back #(
  parameter int RING_BYTES = frod_pkg::FROD_RING_BYTES
) (
  input  logic           clk,
  input  logic           rst_n,
  input  frod_pkg::cmd_t cmd_i,
  input  logic           cmd_empty,
  output logic           cmd_pop,
  output frod_pkg::res_t res_o,
  input  logic           res_full,
  output logic           res_push
);
  import frod_pkg::*;

  localparam int AW = $clog2(RING_BYTES);
  localparam logic [AW:0]   RING_W  = (AW + 1)'(RING_BYTES);
  localparam logic [AW-1:0] RING_M1 = AW'(RING_BYTES - 1);

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p,
                                             input logic [AW-1:0] n);
    logic [AW:0] s;
    s = {1'b0, p} + {1'b0, n};
    if (s >= RING_W) s = s - RING_W;
    return s[AW-1:0];
  endfunction

  logic [7:0] mem [RING_BYTES];
  logic [7:0] mem_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata;

  bst_t state_r, state_nxt;
  cmd_t cur_r;
  logic [AW-1:0] write_pos_r, commit_r, oldest_r, read_pos_r;
  logic [AW:0]   rem_r;
  logic [15:0]   open_r;
  logic [31:0]   total_r, dropped_r;
  logic          pending_r, abandoned_r, drop_mode_r;
  logic [1:0]    cnt_r;
  logic [31:0]   hdr_r;
  logic [7:0]    rdata_r;
  logic          rvalid_r, rend_r, rrestart_r;
  logic [2:0]    wstat_r;

  logic [AW:0]   diff;
  logic [AW-1:0] used, free;
  logic [32:0]   hdr4;
  logic [AW-1:0] adv;
  logic [16:0]   need;
  logic          room_short;

  always_comb begin
    diff = {1'b0, commit_r} - {1'b0, oldest_r};
    if (commit_r < oldest_r) diff = diff + RING_W;
    used = diff[AW-1:0];
    free = RING_M1 - used;
    hdr4 = {1'b0, hdr_r} + 33'd4;
    adv  = (hdr4 > 33'(used)) ? used : hdr4[AW-1:0];
    need = {1'b0, cur_r.frame_len} + 17'd4;
    room_short = (32'(free) < 32'(need)) && (used != '0);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!cmd_empty) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        unique case (cur_r.op)
          OP_WR_START:  state_nxt = cur_r.len_ok ? S_ROOM : S_DONE;
          OP_WR_APPEND: state_nxt = (open_r != '0) ? S_WBYTE : S_DONE;
          OP_READ: begin
            if (rem_r != '0) state_nxt = S_RISSUE;
            else if (used >= AW'(4)) state_nxt = S_HISSUE;
            else state_nxt = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_ROOM: begin
        if (!room_short) state_nxt = S_WHDR;
        else if (used >= AW'(4)) state_nxt = S_HISSUE;
      end
      S_HISSUE: state_nxt = S_HTAKE;
      S_HTAKE:  state_nxt = (cnt_r == 2'd3) ? S_HEVAL : S_HISSUE;
      S_HEVAL: begin
        if (drop_mode_r) state_nxt = S_ROOM;
        else if (hdr4 <= 33'(used)) state_nxt = S_RISSUE;
        else state_nxt = S_DONE;
      end
      S_WHDR:   if (cnt_r == 2'd3) state_nxt = S_WBYTE;
      S_WBYTE:  state_nxt = S_DONE;
      S_RISSUE: state_nxt = S_RTAKE;
      S_RTAKE:  state_nxt = S_DONE;
      S_DONE:   if (!res_full) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outputs and memory port control
  always_comb begin
    cmd_pop   = (state_r == S_IDLE) && !cmd_empty;
    res_push  = (state_r == S_DONE) && !res_full;
    mem_we    = (state_r == S_WHDR) || (state_r == S_WBYTE);
    mem_re    = (state_r == S_HISSUE) || (state_r == S_RISSUE);
    mem_waddr = write_pos_r;
    mem_raddr = (state_r == S_HISSUE) ? wrap_add(oldest_r, AW'(cnt_r)) : read_pos_r;
    unique case (cnt_r)
      2'd0:    mem_wdata = cur_r.frame_len[7:0];
      2'd1:    mem_wdata = cur_r.frame_len[15:8];
      default: mem_wdata = 8'd0;
    endcase
    if (state_r == S_WBYTE) mem_wdata = cur_r.data_byte;
    res_o.read_data      = rdata_r;
    res_o.read_valid     = rvalid_r;
    res_o.frame_end      = rend_r;
    res_o.read_restart   = rrestart_r;
    res_o.write_status   = wstat_r;
    res_o.bytes_used     = (32'(used) > 32'hFFFF) ? 16'hFFFF : 16'(used);
    res_o.frames_total   = total_r;
    res_o.frames_dropped = dropped_r;
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_r      <= cmd_i;
      rdata_r    <= '0;
      rvalid_r   <= 1'b0;
      rend_r     <= 1'b0;
      rrestart_r <= 1'b0;
      wstat_r    <= WS_NONE;
    end
    unique case (state_r)
      S_DISPATCH: begin
        cnt_r <= '0;
        if (cur_r.op == OP_WR_START) begin
          abandoned_r <= (open_r != '0);
          drop_mode_r <= 1'b1;
          if (!cur_r.len_ok) wstat_r <= WS_REJECT;
        end else if (cur_r.op == OP_WR_APPEND) begin
          wstat_r <= (open_r != '0) ? WS_ACCEPT : WS_NO_OPEN;
        end else if (cur_r.op == OP_READ) begin
          drop_mode_r <= 1'b0;
          rrestart_r  <= pending_r;
        end
      end
      S_ROOM:  cnt_r <= '0;
      S_HTAKE: begin
        hdr_r[8*cnt_r +: 8] <= mem_q;
        cnt_r <= cnt_r + 1'b1;
      end
      S_HEVAL: cnt_r <= '0;
      S_WHDR: begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 2'd3) wstat_r <= abandoned_r ? WS_ABANDON : WS_ACCEPT;
      end
      S_WBYTE: if (open_r == 16'd1) wstat_r <= WS_COMMIT;
      S_RTAKE: begin
        rdata_r  <= mem_q;
        rvalid_r <= 1'b1;
        rend_r   <= (rem_r == (AW + 1)'(1));
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      write_pos_r <= '0;
      commit_r    <= '0;
      oldest_r    <= '0;
      read_pos_r  <= '0;
      rem_r       <= '0;
      open_r      <= '0;
      total_r     <= '0;
      dropped_r   <= '0;
      pending_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_DISPATCH: begin
          if (cur_r.op == OP_WR_START) begin
            write_pos_r <= commit_r;
            open_r      <= '0;
          end else if (cur_r.op == OP_READ) begin
            pending_r <= 1'b0;
          end else if (cur_r.op == OP_CLEAR) begin
            write_pos_r <= '0;
            commit_r    <= '0;
            oldest_r    <= '0;
            read_pos_r  <= '0;
            rem_r       <= '0;
            open_r      <= '0;
            total_r     <= '0;
            dropped_r   <= '0;
            pending_r   <= 1'b0;
          end
        end
        S_ROOM: begin
          // Tail shorter than a header: drop what is left in one go
          if (room_short && used < AW'(4)) begin
            oldest_r  <= wrap_add(oldest_r, used);
            dropped_r <= dropped_r + 32'd1;
            if (rem_r != '0) begin
              rem_r     <= '0;
              pending_r <= 1'b1;
            end
          end
        end
        S_HEVAL: begin
          if (drop_mode_r) begin
            oldest_r  <= wrap_add(oldest_r, adv);
            dropped_r <= dropped_r + 32'd1;
            if (rem_r != '0) begin
              rem_r     <= '0;
              pending_r <= 1'b1;
            end
          end else if (hdr4 <= 33'(used)) begin
            rem_r      <= hdr4[AW:0];
            read_pos_r <= oldest_r;
          end
        end
        S_WHDR: begin
          write_pos_r <= wrap_add(write_pos_r, AW'(1));
          if (cnt_r == 2'd3) open_r <= cur_r.frame_len;
        end
        S_WBYTE: begin
          write_pos_r <= wrap_add(write_pos_r, AW'(1));
          open_r      <= open_r - 16'd1;
          if (open_r == 16'd1) begin
            commit_r <= wrap_add(write_pos_r, AW'(1));
            total_r  <= total_r + 32'd1;
          end
        end
        S_RTAKE: begin
          read_pos_r <= wrap_add(read_pos_r, AW'(1));
          rem_r      <= rem_r - 1'b1;
          if (rem_r == (AW + 1)'(1)) oldest_r <= wrap_add(read_pos_r, AW'(1));
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_end_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res_o.frame_end |-> res_o.read_valid)
    else $error("frame end without read data");

  a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res_o.read_valid |-> res_o.write_status == WS_NONE)
    else $error("read result carries a write status");

  a_commit_counts: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WBYTE && open_r == 16'd1 |=> total_r == $past(total_r) + 32'd1)
    else $error("commit did not advance frame count");

  a_drop_only_in_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_HEVAL && state_r != S_ROOM && state_r != S_DISPATCH
    |=> $stable(dropped_r))
    else $error("drop count moved outside room making");
`endif

endmodule
